### rtl/cfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the checksum frame receiver.
// No dependencies.
package cfr_pkg;

  localparam int unsigned MAX_GROUPS = 15;

  localparam logic [7:0] HEAD_A = 8'hAA;
  localparam logic [7:0] HEAD_B = 8'h55;
  localparam logic [7:0] TAIL_A = 8'hA0;
  localparam logic [7:0] TAIL_B = 8'h5F;

  localparam int unsigned NUM_FIELDS  = 5;
  localparam int unsigned NUM_PAYLOAD = 9;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_HEADER   = 3'd2,
    ST_ADDRESS  = 3'd3,
    ST_TRAILER  = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  group_count;
    logic [7:0]  command_code;
    logic [7:0]  port_setting;
    logic [7:0]  sub_command;
    logic [15:0] dest_x;
    logic [15:0] dest_z;
    logic [7:0]  tray_slot;
    logic [15:0] plat_x;
    logic [15:0] plat_z;
  } cfr_result_t;

endpackage

### rtl/cfr_if.sv
`timescale 1ns / 1ps
// Handshake channels of the checksum frame receiver: byte in, config, result.
// No dependencies.
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] local_address;
  modport source (output valid, output local_address, input ready);
  modport sink (input valid, input local_address, output ready);
endinterface

interface cfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  group_count;
  logic [7:0]  command_code;
  logic [7:0]  port_setting;
  logic [7:0]  sub_command;
  logic [15:0] dest_x;
  logic [15:0] dest_z;
  logic [7:0]  tray_slot;
  logic [15:0] plat_x;
  logic [15:0] plat_z;
  modport source (output valid, output status, output group_count, output command_code,
                  output port_setting, output sub_command, output dest_x,
                  output dest_z, output tray_slot, output plat_x, output plat_z,
                  input ready);
  modport sink (input valid, input status, input group_count, input command_code,
                input port_setting, input sub_command, input dest_x,
                input dest_z, input tray_slot, input plat_x, input plat_z,
                output ready);
endinterface

### rtl/cfr_parser.sv
`timescale 1ns / 1ps
// Frame parser: byte counter, checksum, field capture and status decision.
// Depends on cfr_pkg and the channels in cfr_if.
module cfr_parser #(
  parameter int unsigned MaxGroups = cfr_pkg::MAX_GROUPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfr_byte_if.sink            rx_i,
  cfr_cfg_if.sink             cfg_i,
  input  logic                take_i,
  output logic                push_o,
  output cfr_pkg::cfr_result_t result_o
);
  import cfr_pkg::*;

  localparam int unsigned IdxW = $clog2(10 + 8 * MaxGroups);
  localparam int unsigned GrpW = $clog2(MaxGroups + 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic [7:0]      sum_q, sum_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [7:0]      fld_q [NUM_FIELDS];
  logic [7:0]      fld_d [NUM_FIELDS];
  logic [7:0]      pay_q [NUM_PAYLOAD];
  logic [7:0]      pay_d [NUM_PAYLOAD];
  logic [7:0]      pay_now [NUM_PAYLOAD];
  logic [7:0]      tail_q, tail_d;
  logic [7:0]      addr_q;
  logic [IdxW-1:0] trail_pos;
  logic            fire;
  logic [7:0]      b;

  assign rx_i.ready  = take_i;
  assign cfg_i.ready = 1'b1;
  assign fire        = rx_i.valid && take_i;
  assign b           = rx_i.rx_byte;
  assign trail_pos   = IdxW'(8) + (IdxW'(grp_q) << 3);

  always_comb begin
    for (int k = 0; k < NUM_PAYLOAD; k++) begin
      pay_now[k] = (idx_q == IdxW'(8 + k)) ? b : pay_q[k];
    end
  end

  always_comb begin
    idx_d    = idx_q;
    grp_d    = grp_q;
    sum_d    = sum_q;
    hdr_ok_d = hdr_ok_q;
    fld_d    = fld_q;
    pay_d    = pay_q;
    tail_d   = tail_q;
    push_o   = 1'b0;
    result_o = '0;
    if (fire) begin
      idx_d = idx_q + IdxW'(1);
      if (idx_q == IdxW'(0)) begin
        hdr_ok_d = hdr_ok_q && (b == HEAD_A);
      end else if (idx_q == IdxW'(1)) begin
        hdr_ok_d = hdr_ok_q && (b == HEAD_B);
      end else if (idx_q == IdxW'(2)) begin
        if (b > 8'(MaxGroups)) begin
          push_o               = 1'b1;
          result_o.status      = ST_TOO_LONG;
          result_o.group_count = b;
          idx_d                = '0;
        end else begin
          grp_d    = GrpW'(b);
          fld_d[0] = b;
          sum_d    = sum_q + b;
        end
      end else if (idx_q <= IdxW'(6)) begin
        for (int k = 1; k < NUM_FIELDS; k++) begin
          if (idx_q == IdxW'(k + 2)) fld_d[k] = b;
        end
        sum_d = sum_q + b;
      end else if (idx_q == IdxW'(7)) begin
        sum_d = sum_q - b;
      end else begin
        pay_d = pay_now;
        if (idx_q < trail_pos) begin
          sum_d = sum_q + b;
        end else if (idx_q == trail_pos) begin
          tail_d = b;
        end else begin
          push_o = 1'b1;
          priority if (!hdr_ok_q) begin
            result_o.status = ST_HEADER;
          end else if (fld_q[2] != addr_q) begin
            result_o.status = ST_ADDRESS;
          end else if (sum_q != 8'd0) begin
            result_o.status = ST_CHECKSUM;
          end else if (tail_q != TAIL_A || b != TAIL_B) begin
            result_o.status = ST_TRAILER;
          end else begin
            result_o.status = ST_OK;
          end
          result_o.group_count  = fld_q[0];
          result_o.command_code = fld_q[1];
          result_o.port_setting = fld_q[3];
          result_o.sub_command  = fld_q[4];
          result_o.dest_x       = {pay_now[0], pay_now[1]};
          result_o.dest_z       = {pay_now[2], pay_now[3]};
          result_o.tray_slot    = pay_now[4];
          result_o.plat_x       = {pay_now[5], pay_now[6]};
          result_o.plat_z       = {pay_now[7], pay_now[8]};
          idx_d                 = '0;
        end
      end
      // restart for the next frame
      if (push_o) begin
        grp_d    = '0;
        sum_d    = '0;
        hdr_ok_d = 1'b1;
        tail_d   = '0;
        for (int k = 0; k < NUM_FIELDS; k++) fld_d[k] = '0;
        for (int k = 0; k < NUM_PAYLOAD; k++) pay_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      grp_q    <= '0;
      sum_q    <= '0;
      hdr_ok_q <= 1'b1;
      tail_q   <= '0;
      addr_q   <= '0;
      for (int k = 0; k < NUM_FIELDS; k++) fld_q[k] <= '0;
      for (int k = 0; k < NUM_PAYLOAD; k++) pay_q[k] <= '0;
    end else begin
      idx_q    <= idx_d;
      grp_q    <= grp_d;
      sum_q    <= sum_d;
      hdr_ok_q <= hdr_ok_d;
      tail_q   <= tail_d;
      fld_q    <= fld_d;
      pay_q    <= pay_d;
      if (cfg_i.valid) addr_q <= cfg_i.local_address;
    end
  end

endmodule

### rtl/cfr_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one finished word until the sink takes it.
// Depends on cfr_pkg and cfr_res_if.
module cfr_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfr_pkg::cfr_result_t result_i,
  output logic                take_o,
  cfr_res_if.source           res_o
);
  import cfr_pkg::*;

  logic        valid_q, valid_d;
  cfr_result_t data_q;

  assign take_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) data_q <= result_i;
  end

  assign res_o.valid        = valid_q;
  assign res_o.status       = data_q.status;
  assign res_o.group_count  = data_q.group_count;
  assign res_o.command_code = data_q.command_code;
  assign res_o.port_setting = data_q.port_setting;
  assign res_o.sub_command  = data_q.sub_command;
  assign res_o.dest_x       = data_q.dest_x;
  assign res_o.dest_z       = data_q.dest_z;
  assign res_o.tray_slot    = data_q.tray_slot;
  assign res_o.plat_x       = data_q.plat_x;
  assign res_o.plat_z       = data_q.plat_z;

endmodule

### rtl/checksum_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Checksum frame receiver top level: parser feeding a result register.
// Takes one byte per cycle while not stalled; the result is valid in the cycle after the byte that ends the frame.
// The byte channel stalls only while a held result is not taken.
// Reset clears the byte counter, checksum, captured fields and local_address,
// and empties the result register.
module checksum_frame_receiver_unit #(
  parameter int unsigned MaxGroups = cfr_pkg::MAX_GROUPS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfr_byte_if.sink  rx_i,
  cfr_cfg_if.sink   cfg_i,
  cfr_res_if.source res_o
);
  import cfr_pkg::*;

  logic        push;
  logic        take;
  cfr_result_t result;

  cfr_parser #(
    .MaxGroups(MaxGroups)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .cfg_i   (cfg_i),
    .take_i  (take),
    .push_o  (push),
    .result_o(result)
  );

  cfr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .result_i(result),
    .take_o  (take),
    .res_o   (res_o)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for checksum_frame_receiver_unit: queued driver, clocked monitor,
// in-bench frame predictor. Needs cfr_pkg, the cfr_*_if interfaces and the top level.
module testbench;
  import cfr_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 150;
  localparam int CALM_FROM     = 600;
  localparam int CALM_TO       = 1100;
  localparam int PHASE_BYTES   = 160;
  localparam int MAX_PRINTS    = 40;

  typedef enum int {
    FK_GOOD, FK_BAD_SUM, FK_BAD_HEAD, FK_BAD_ADDR, FK_BAD_TAIL, FK_TOO_LONG, FK_NOISE
  } frame_kind_e;

  typedef struct packed {
    bit         is_cfg;
    logic [7:0] data;
  } rx_word_t;

  logic clk = 1'b0;
  logic rst_n;

  cfr_byte_if rx_if ();
  cfr_cfg_if  cfg_if ();
  cfr_res_if  res_if ();

  checksum_frame_receiver_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_word_t    rx_words_q[$];
  cfr_result_t frame_results_q[$];

  // Predictor state
  logic [7:0] station_addr;
  int         frame_pos;
  logic [7:0] groups_seen;
  logic [7:0] csum;
  bit         hdr_ok;
  logic [7:0] hdr_fields[5];
  logic [7:0] body[9];
  logic [7:0] tail0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  int cycle_cnt      = 0;
  int hold_cycles    = 0;
  bit hold_done      = 1'b0;
  bit send_rx;
  bit send_cfg;
  rx_word_t next_word;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("ERROR %0t ns: %s", $realtime, what);
  endtask

  task automatic check_field(input string fname, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", fname, got, want));
  endtask

  task automatic clear_frame();
    frame_pos   = 0;
    groups_seen = '0;
    csum        = '0;
    hdr_ok      = 1'b1;
    tail0       = '0;
    foreach (hdr_fields[i]) hdr_fields[i] = '0;
    foreach (body[i]) body[i] = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    cfr_result_t r;
    int trail_pos;
    r = '0;
    trail_pos = 8 + 8 * int'(groups_seen);
    if (frame_pos == 0) begin
      hdr_ok = hdr_ok && (b == HEAD_A);
    end else if (frame_pos == 1) begin
      hdr_ok = hdr_ok && (b == HEAD_B);
    end else if (frame_pos == 2) begin
      groups_seen   = b;
      hdr_fields[0] = b;
      if (b > MAX_GROUPS) begin
        r.status      = ST_TOO_LONG;
        r.group_count = b;
        frame_results_q.push_back(r);
        clear_frame();
        return;
      end
      csum = csum + b;
    end else if (frame_pos <= 6) begin
      hdr_fields[frame_pos - 2] = b;
      csum = csum + b;
    end else if (frame_pos == 7) begin
      csum = csum - b;
    end else begin
      if (frame_pos <= 16) body[frame_pos - 8] = b;
      if (frame_pos < trail_pos) begin
        csum = csum + b;
      end else if (frame_pos == trail_pos) begin
        tail0 = b;
      end else begin
        if (!hdr_ok) r.status = ST_HEADER;
        else if (hdr_fields[2] != station_addr) r.status = ST_ADDRESS;
        else if (csum != 8'd0) r.status = ST_CHECKSUM;
        else if (tail0 != TAIL_A || b != TAIL_B) r.status = ST_TRAILER;
        else r.status = ST_OK;
        r.group_count  = hdr_fields[0];
        r.command_code = hdr_fields[1];
        r.port_setting = hdr_fields[3];
        r.sub_command  = hdr_fields[4];
        r.dest_x       = {body[0], body[1]};
        r.dest_z       = {body[2], body[3]};
        r.tray_slot    = body[4];
        r.plat_x       = {body[5], body[6]};
        r.plat_z       = {body[7], body[8]};
        frame_results_q.push_back(r);
        clear_frame();
        return;
      end
    end
    frame_pos++;
  endtask

  task automatic check_result();
    cfr_result_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result word with no frame pending");
      return;
    end
    want = frame_results_q.pop_front();
    results_seen++;
    check_field("status", res_if.status, want.status);
    check_field("group_count", res_if.group_count, want.group_count);
    check_field("command_code", res_if.command_code, want.command_code);
    check_field("port_setting", res_if.port_setting, want.port_setting);
    check_field("sub_command", res_if.sub_command, want.sub_command);
    check_field("dest_x", res_if.dest_x, want.dest_x);
    check_field("dest_z", res_if.dest_z, want.dest_z);
    check_field("tray_slot", res_if.tray_slot, want.tray_slot);
    check_field("plat_x", res_if.plat_x, want.plat_x);
    check_field("plat_z", res_if.plat_z, want.plat_z);
  endtask

  function automatic bit gap_now();
    return ($urandom_range(99) < 10) && !(cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO);
  endfunction

  function automatic logic [7:0] nz8();
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic push_cfg(input logic [7:0] addr);
    rx_word_t w;
    w.is_cfg = 1'b1;
    w.data   = addr;
    rx_words_q.push_back(w);
  endtask

  task automatic push_frame(input frame_kind_e kind, input int groups, input logic [7:0] addr);
    logic [7:0] fb[$];
    logic [7:0] len_byte;
    logic [7:0] sum;
    rx_word_t   w;
    int         n;
    if (kind == FK_NOISE) begin
      len_byte = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom());
      n = (len_byte > MAX_GROUPS) ? 3 : 10 + 8 * int'(len_byte);
      for (int i = 0; i < n; i++) fb.push_back(i == 2 ? len_byte : 8'($urandom()));
    end else if (kind == FK_TOO_LONG) begin
      fb.push_back(HEAD_A);
      fb.push_back(HEAD_B);
      fb.push_back(groups > MAX_GROUPS ? 8'(groups) : 8'($urandom_range(255, MAX_GROUPS + 1)));
    end else begin
      fb.push_back(HEAD_A);
      fb.push_back(HEAD_B);
      fb.push_back(8'(groups));
      fb.push_back(8'($urandom()));
      fb.push_back(kind == FK_BAD_ADDR ? addr ^ nz8() : addr);
      fb.push_back(8'($urandom()));
      fb.push_back(8'($urandom()));
      fb.push_back(8'd0);
      for (int i = 0; i < 8 * groups; i++) fb.push_back(8'($urandom()));
      sum = '0;
      for (int i = 2; i < fb.size(); i++) if (i != 7) sum = sum + fb[i];
      fb[7] = sum;
      fb.push_back(TAIL_A);
      fb.push_back(TAIL_B);
      case (kind)
        FK_BAD_SUM:  fb[7] = fb[7] ^ nz8();
        FK_BAD_HEAD: begin
          n = $urandom_range(1);
          fb[n] = fb[n] ^ nz8();
        end
        FK_BAD_TAIL: begin
          n = fb.size() - 1 - $urandom_range(1);
          fb[n] = fb[n] ^ nz8();
        end
        default: ;
      endcase
    end
    foreach (fb[i]) begin
      w.is_cfg = 1'b0;
      w.data   = fb[i];
      rx_words_q.push_back(w);
    end
  endtask

  task automatic push_random_phase(input logic [7:0] addr, input int nbytes);
    int          start;
    int          pick;
    int          grp;
    frame_kind_e kind;
    start = rx_words_q.size();
    while (rx_words_q.size() - start < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 55) kind = FK_GOOD;
      else if (pick < 63) kind = FK_BAD_SUM;
      else if (pick < 70) kind = FK_BAD_HEAD;
      else if (pick < 77) kind = FK_BAD_ADDR;
      else if (pick < 85) kind = FK_BAD_TAIL;
      else if (pick < 92) kind = FK_TOO_LONG;
      else kind = FK_NOISE;
      pick = $urandom_range(99);
      if (pick < 70) grp = $urandom_range(2);
      else if (pick < 95) grp = $urandom_range(7, 3);
      else grp = $urandom_range(MAX_GROUPS, 8);
      push_frame(kind, grp, addr);
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Driver: byte and config channels, fed from rx_words_q; accepted bytes also feed the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_if.valid && rx_if.ready) parse_rx_byte(rx_if.rx_byte);
      if (cfg_if.valid && cfg_if.ready) station_addr = cfg_if.local_address;
      quiet_cycles = (rx_if.valid || cfg_if.valid) ? 0 : quiet_cycles + 1;
      if (!(rx_if.valid && !rx_if.ready) && !(cfg_if.valid && !cfg_if.ready)) begin
        send_rx  = 1'b0;
        send_cfg = 1'b0;
        if (rx_words_q.size() != 0) begin
          if (rx_words_q[0].is_cfg) begin
            if (frame_results_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              next_word = rx_words_q.pop_front();
              cfg_if.local_address <= next_word.data;
              send_cfg = 1'b1;
            end
          end else if (!gap_now()) begin
            next_word = rx_words_q.pop_front();
            rx_if.rx_byte <= next_word.data;
            send_rx = 1'b1;
          end
        end
        rx_if.valid  <= send_rx;
        cfg_if.valid <= send_cfg;
      end
    end
  end

  // Monitor: result channel
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) check_result();
      res_if.ready <= (hold_cycles == 0) && !gap_now();
    end
  end

  // Hold off the result side once so the block backs up into the byte channel
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && results_seen >= 15) begin
      hold_cycles <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end
  end

  initial begin
    logic [7:0] phase_addr;
    rst_n                = 1'b0;
    rx_if.valid          = 1'b0;
    rx_if.rx_byte        = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.local_address = '0;
    res_if.ready         = 1'b0;
    station_addr         = '0;
    clear_frame();

    push_cfg(8'h00);
    push_frame(FK_GOOD, 0, 8'h00);
    push_frame(FK_TOO_LONG, MAX_GROUPS + 1, 8'h00);
    push_frame(FK_TOO_LONG, 255, 8'h00);
    push_frame(FK_BAD_HEAD, 0, 8'h00);

    push_cfg(8'hFF);
    push_frame(FK_GOOD, MAX_GROUPS, 8'hFF);
    push_random_phase(8'hFF, PHASE_BYTES);
    for (int p = 0; p < 5; p++) begin
      phase_addr = (p == 1) ? 8'h00 : (p == 3) ? 8'hAA : 8'($urandom());
      push_cfg(phase_addr);
      push_random_phase(phase_addr, PHASE_BYTES);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (rx_words_q.size() != 0 || rx_if.valid || cfg_if.valid ||
           frame_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS checksum_frame_receiver_unit");
    end else begin
      $display("FAIL checksum_frame_receiver_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL checksum_frame_receiver_unit");
    $finish;
  end

endmodule

### checksum_frame_receiver_unit.f
rtl/cfr_pkg.sv
rtl/cfr_if.sv
rtl/cfr_parser.sv
rtl/cfr_out_reg.sv
rtl/checksum_frame_receiver_unit.sv
tb/testbench.sv
